FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the window tracker checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, disabled while in reset.
`define MCTW_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle, disabled while in reset.
`define MCTW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mctw_pkg.sv
// ----------------------------------------------------------------------------
// mctw_pkg
// Shared widths, types and helpers of the covering window tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package mctw_pkg;

  localparam int MAX_TERMS  = 16;
  localparam int IDX_W      = $clog2(MAX_TERMS);
  localparam int CNT_W      = $clog2(MAX_TERMS + 1);
  localparam int MASK_EXT_W = MAX_TERMS + 1;
  localparam int POS_W      = 32;
  localparam int TERM_W     = 4;
  localparam int TC_W       = 5;

  typedef logic [MAX_TERMS-1:0] mctw_mask_t;

  // One classified word handed from front to back.
  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [TERM_W-1:0] term;
    logic              first;
    logic              term_ok;
    logic [CNT_W-1:0]  count;
  } mctw_item_t;

  // Clamp the programmed term count into 1..MAX_TERMS.
  function automatic logic [CNT_W-1:0] eff_count(input logic [TC_W-1:0] tc);
    logic [CNT_W-1:0] n;
    if (tc == '0) begin
      n = CNT_W'(1);
    end else if (32'(tc) > MAX_TERMS) begin
      n = CNT_W'(MAX_TERMS);
    end else begin
      n = CNT_W'(tc);
    end
    return n;
  endfunction

  // Mask with the low n bits set.
  function automatic mctw_mask_t need_mask(input logic [CNT_W-1:0] n);
    logic [MASK_EXT_W-1:0] t;
    t = (MASK_EXT_W'(1) << n) - MASK_EXT_W'(1);
    return t[MAX_TERMS-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mctw_front.sv
// ----------------------------------------------------------------------------
// mctw_front
// Input side: term count register, word classification and queue push.
// ----------------------------------------------------------------------------
`default_nettype none

module mctw_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [mctw_pkg::TC_W-1:0]     cfg_data_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire [mctw_pkg::POS_W-1:0]    position_i,
  input  wire [mctw_pkg::TERM_W-1:0]   term_i,
  input  wire                          first_i,
  input  wire                          q_full_i,
  output logic                         q_push_o,
  output mctw_pkg::mctw_item_t         q_item_o
);
  import mctw_pkg::*;

  logic [TC_W-1:0]  term_count_q;
  logic [CNT_W-1:0] n_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_count_q <= TC_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      term_count_q <= cfg_data_i;
    end
  end

  assign n_eff = eff_count(term_count_q);

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_item_o.position = position_i;
    q_item_o.term     = term_i;
    q_item_o.first    = first_i;
    q_item_o.term_ok  = CNT_W'(term_i) < n_eff;  // out-of-range term is not recorded in the store or mask
    q_item_o.count    = n_eff;
  end

endmodule

`default_nettype wire

FILE: rtl/mctw_queue.sv
// ----------------------------------------------------------------------------
// mctw_queue
// Two-entry queue of classified words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module mctw_queue (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        push_i,
  input  wire mctw_pkg::mctw_item_t  item_i,
  output logic                       full_o,
  input  wire                        pop_i,
  output logic                       valid_o,
  output mctw_pkg::mctw_item_t       item_o
);
  import mctw_pkg::*;

  mctw_item_t  slot_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  fill_q;

  assign full_o  = fill_q == 2'd2;
  assign valid_o = fill_q != 2'd0;
  assign item_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mctw_back.sv
// ----------------------------------------------------------------------------
// mctw_back
// Execution side: last-seen store, min/max scan, best window and result word.
// ----------------------------------------------------------------------------
`default_nettype none

module mctw_back (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             q_valid_i,
  input  wire mctw_pkg::mctw_item_t       q_item_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic                            found_o,
  output logic [mctw_pkg::POS_W-1:0]      window_start_o,
  output logic [mctw_pkg::POS_W-1:0]      window_end_o
);
  import mctw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DRAIN, ST_DECIDE, ST_EMIT
  } state_e;

  state_e           state_q, state_d;
  mctw_mask_t       mask_q, mask_d, mask_new;
  logic [POS_W-1:0] best_start_q, best_start_d, best_end_q, best_end_d;
  logic             best_valid_q, best_valid_d;
  logic [POS_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic             rd_vld_q, rd_vld_d;
  logic             out_vld_q, out_vld_d;
  logic             found_q, found_d;
  logic [POS_W-1:0] out_start_q, out_start_d, out_end_q, out_end_d;

  // last-seen store
  logic [POS_W-1:0] ls_mem [MAX_TERMS];
  logic [POS_W-1:0] rd_data_q;
  logic             mem_we;

  logic [POS_W-1:0] cand_w, best_w;
  logic             out_free;

  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;
  assign mem_we   = q_pop_o && q_item_i.term_ok;
  assign out_free = !out_vld_q || !out_stall_i;
  assign cand_w   = hi_q - lo_q;
  assign best_w   = best_end_q - best_start_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ls_mem[q_item_i.term] <= q_item_i.position;
    end
    rd_data_q <= ls_mem[cnt_q];
  end

  always_comb begin
    state_d      = state_q;
    mask_d       = mask_q;
    best_start_d = best_start_q;
    best_end_d   = best_end_q;
    best_valid_d = best_valid_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    cnt_d        = cnt_q;
    n_d          = n_q;
    rd_vld_d     = 1'b0;
    out_vld_d    = out_vld_q && out_stall_i;
    found_d      = found_q;
    out_start_d  = out_start_q;
    out_end_d    = out_end_q;
    mask_new     = q_item_i.first ? '0 : mask_q;

    // fold the word read last cycle into the running min/max
    if (rd_vld_q) begin
      if (rd_data_q < lo_q) lo_d = rd_data_q;
      if (rd_data_q > hi_q) hi_d = rd_data_q;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_item_i.first) begin
            best_start_d = '0;
            best_end_d   = '1;
            best_valid_d = 1'b0;
          end
          if (q_item_i.term_ok) begin
            mask_new = mask_new | (mctw_mask_t'(1) << q_item_i.term);
          end
          mask_d = mask_new;
          n_d    = q_item_i.count;
          if (q_item_i.term_ok &&
              ((mask_new & need_mask(q_item_i.count)) == need_mask(q_item_i.count))) begin
            cnt_d   = '0;
            lo_d    = '1;
            hi_d    = '0;
            state_d = ST_SCAN;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_SCAN: begin
        rd_vld_d = 1'b1;
        if (CNT_W'(cnt_q) == n_q - CNT_W'(1)) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!best_valid_q || (cand_w < best_w)) begin
          best_start_d = lo_q;
          best_end_d   = hi_q;
          best_valid_d = 1'b1;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_vld_d   = 1'b1;
          found_d     = best_valid_q;
          out_start_d = best_start_q;
          out_end_d   = best_end_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mask_q       <= '0;
      best_start_q <= '0;
      best_end_q   <= '1;
      best_valid_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      cnt_q        <= '0;
      n_q          <= CNT_W'(1);
      found_q      <= 1'b0;
      out_start_q  <= '0;
      out_end_q    <= '1;
    end else begin
      state_q      <= state_d;
      mask_q       <= mask_d;
      best_start_q <= best_start_d;
      best_end_q   <= best_end_d;
      best_valid_q <= best_valid_d;
      rd_vld_q     <= rd_vld_d;
      out_vld_q    <= out_vld_d;
      cnt_q        <= cnt_d;
      n_q          <= n_d;
      found_q      <= found_d;
      out_start_q  <= out_start_d;
      out_end_q    <= out_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

  assign out_valid_o    = out_vld_q;
  assign found_o        = found_q;
  assign window_start_o = out_start_q;
  assign window_end_o   = out_end_q;

endmodule

`default_nettype wire

FILE: rtl/minimum_covering_window_tracker_core.sv
// ----------------------------------------------------------------------------
// minimum_covering_window_tracker_core
// Narrowest text window that holds every query term, tracked over a stream.
//
// Each input word is one occurrence of a query term at a text position. The
// block remembers the last position of every term and, once all term_count
// terms have appeared, checks the window from the oldest last-seen position
// to the newest; the narrowest one wins, ties keep the earlier window. Every
// input word yields exactly one result word carrying the best window so far
// (found low, start 0, end all ones while none exists). first_i clears the
// tracking before its word is handled. Terms at or above the clamped term
// count are ignored but still yield a result. A word that completes coverage
// scans the last-seen store one entry a cycle in ST_SCAN, then passes
// ST_DRAIN and ST_DECIDE to ST_EMIT; any other word goes straight to
// ST_EMIT. A two-word queue sits between the input and the back end, and the
// result register lets the next word start while a result is still stalled.
// The user must write term_count through the configuration port (always
// ready) only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module minimum_covering_window_tracker_core (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // configuration
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [mctw_pkg::TC_W-1:0]     cfg_data_i,
  // input words
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire [mctw_pkg::POS_W-1:0]    position_i,
  input  wire [mctw_pkg::TERM_W-1:0]   term_i,
  input  wire                          first_i,
  // result words
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         found_o,
  output logic [mctw_pkg::POS_W-1:0]   window_start_o,
  output logic [mctw_pkg::POS_W-1:0]   window_end_o
);
  import mctw_pkg::*;

  logic       q_push, q_full, q_pop, q_valid;
  mctw_item_t q_wr_item, q_rd_item;

  // front: config register, term range check, clamped count
  mctw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .position_i  (position_i),
    .term_i      (term_i),
    .first_i     (first_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (q_wr_item)
  );

  // decoupling queue
  mctw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_wr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_rd_item)
  );

  // back: store update, min/max scan, best window, result register
  mctw_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_rd_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .window_start_o (window_start_o),
    .window_end_o   (window_end_o)
  );

endmodule

`default_nettype wire

FILE: rtl/mctw_checker.sv
// ----------------------------------------------------------------------------
// mctw_checker
// Port-level checks of the covering window tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mctw_checker (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        out_valid_o,
  input wire                        out_stall_i,
  input wire                        found_o,
  input wire [mctw_pkg::POS_W-1:0]  window_start_o,
  input wire [mctw_pkg::POS_W-1:0]  window_end_o
);
  import mctw_pkg::*;

  `MCTW_ASSERT_NEXT(a_valid_holds, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result word dropped while stalled")

  `MCTW_ASSERT_NEXT(a_word_holds, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(found_o) && $stable(window_start_o) && $stable(window_end_o), "stalled result word changed")

  `MCTW_ASSERT_SAME(a_empty_window, clk_i, rst_ni, out_valid_o && !found_o, (window_start_o == '0) && (window_end_o == '1), "no window but bounds not at their empty values")

  `MCTW_ASSERT_SAME(a_ordered_window, clk_i, rst_ni, out_valid_o && found_o, window_start_o <= window_end_o, "window start beyond window end")

endmodule

bind minimum_covering_window_tracker_core mctw_checker u_mctw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .found_o        (found_o),
  .window_start_o (window_start_o),
  .window_end_o   (window_end_o)
);

`default_nettype wire
